/* rtl/ulfc_pkg.sv */
// shared types, codes and character constants for the uart rx line frame collector
package ulfc_pkg;

    // item kinds on the input channel
    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_RESTART = 2'd1,
        KIND_READ    = 2'd2,
        KIND_NOP     = 2'd3
    } t_kind;

    // receive modes held in the rx_type register
    typedef enum logic [1:0] {
        RXT_LINE   = 2'd0,
        RXT_RAW    = 2'd1,
        RXT_MARKER = 2'd2,
        RXT_INERT  = 2'd3
    } t_rx_type;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_RX_TYPE      = 2'd0,
        CFG_START_MARKER = 2'd1,
        CFG_END_MARKER   = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_index;

    localparam int DEFAULT_BUF_DEPTH = 256;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam int         WIN_LEN = 8;
    localparam int         TAG_LEN = 5;

    // "+IPD," byte by position
    function automatic logic [7:0] ipd_tag(input logic [2:0] pos);
        logic [7:0] v;
        case (pos)
            3'd0:    v = 8'h2B;
            3'd1:    v = 8'h49;
            3'd2:    v = 8'h50;
            3'd3:    v = 8'h44;
            3'd4:    v = 8'h2C;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // status reported with every result
    typedef struct packed {
        logic       frame_done;
        logic       cr_pending;
        logic [7:0] link_id;
        logic       link_id_fresh;
    } t_status;

endpackage

/* rtl/ulfc_store.sv */
// single-port byte buffer with registered read data
module ulfc_store #(
    parameter int BUF_DEPTH = ulfc_pkg::DEFAULT_BUF_DEPTH,
    parameter int AW        = $clog2(BUF_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    import ulfc_pkg::*;

    logic [7:0] r_mem [BUF_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ulfc_ctrl.sv */
// status registers, receive mode logic, link sniffing and buffer write sequencing
module ulfc_ctrl #(
    parameter int BUF_DEPTH = ulfc_pkg::DEFAULT_BUF_DEPTH,
    parameter int AW        = $clog2(BUF_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_take,
    input  logic [1:0]        i_mode,
    input  logic [7:0]        i_rx_byte,
    input  logic [7:0]        i_frames_wanted,
    output logic              o_busy,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output logic [7:0]        o_wdata,
    output logic [8:0]        o_count,
    output ulfc_pkg::t_status o_status
);
    import ulfc_pkg::*;

    localparam int CW = $clog2(BUF_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(BUF_DEPTH);
    localparam logic [CW-1:0] LAST = CW'(BUF_DEPTH - 1);

    logic [CW-1:0] r_cnt,    n_cnt;
    logic          r_cr,     n_cr;
    logic          r_done,   n_done;
    logic [7:0]    r_frames, n_frames;
    logic [3:0]    r_pos,    n_pos;
    logic [7:0]    r_link,   n_link;
    logic [7:0]    r_win [WIN_LEN];
    logic          win_we;
    logic [2:0]    win_idx;
    logic          fresh;

    logic [1:0]    r_rx_type;
    logic [7:0]    r_start, r_end;

    logic          r_wr2,  n_wr2;
    logic [AW-1:0] r_wr2_addr, n_wr2_addr;

    logic          w1_en;
    logic [CW-1:0] w1_pos;
    logic [7:0]    w1_data;

    logic [CW:0]   cnt_p1, cnt_p2;
    logic [CW-1:0] mk_base;
    logic [3:0]    sn_p, sn_p1;
    logic          tag_hit;

    always_comb begin
        cnt_p1 = {1'b0, r_cnt} + (CW+1)'(1);
        cnt_p2 = {1'b0, r_cnt} + (CW+1)'(2);
        mk_base = (i_rx_byte == r_start) ? '0 : r_cnt;
        tag_hit = 1'b1;
        for (int k = 0; k < TAG_LEN; k++) begin
            if (r_win[k] != ipd_tag(3'(k))) tag_hit = 1'b0;
        end
        sn_p  = (i_rx_byte == CH_PLUS) ? 4'd0 : r_pos;
        sn_p1 = sn_p + 4'd1;
    end

    always_comb begin
        n_cnt      = r_cnt;
        n_cr       = r_cr;
        n_done     = r_done;
        n_frames   = r_frames;
        n_pos      = r_pos;
        n_link     = r_link;
        win_we     = 1'b0;
        win_idx    = sn_p[2:0];
        fresh      = 1'b0;
        n_wr2      = 1'b0;
        n_wr2_addr = r_wr2_addr;
        w1_en      = 1'b0;
        w1_pos     = r_cnt;
        w1_data    = i_rx_byte;
        if (i_take) begin
            case (t_kind'(i_mode))
                KIND_BYTE: begin
                    case (t_rx_type'(r_rx_type))
                        RXT_LINE: begin
                            if (!r_done) begin
                                if (r_cr) begin
                                    if (i_rx_byte != CH_LF) begin
                                        n_cnt = '0;
                                        n_cr  = 1'b0;
                                    end else if (r_frames != 8'd0) begin
                                        n_frames = r_frames - 8'd1;
                                        n_cr     = 1'b0;
                                        w1_en    = (r_cnt < FULL);
                                        w1_data  = CH_CR;
                                        // LF goes in the following cycle
                                        n_wr2      = (cnt_p1 < {1'b0, FULL});
                                        n_wr2_addr = AW'(cnt_p1);
                                        n_cnt = (cnt_p2 > {1'b0, FULL}) ? FULL
                                                                        : CW'(cnt_p2);
                                    end else begin
                                        n_done = 1'b1;
                                    end
                                end else if (i_rx_byte == CH_CR) begin
                                    n_cr = 1'b1;
                                end else begin
                                    w1_en = (r_cnt < FULL);
                                    n_cnt = (r_cnt >= LAST) ? '0 : CW'(cnt_p1);
                                end
                            end
                        end
                        RXT_RAW: begin
                            if (!r_done) begin
                                w1_en = (r_cnt < FULL);
                                if (r_cnt < LAST) begin
                                    n_cnt = CW'(cnt_p1);
                                end else begin
                                    n_done = 1'b1;
                                end
                            end
                        end
                        RXT_MARKER: begin
                            if (!r_done && !r_cr && r_cnt < LAST) begin
                                w1_en  = 1'b1;
                                w1_pos = mk_base;
                                n_cnt  = mk_base + CW'(1);
                                if (i_rx_byte == r_end) n_done = 1'b1;
                            end else begin
                                n_cnt  = '0;
                                n_cr   = 1'b0;
                                n_done = 1'b0;
                            end
                            if (r_pos < 4'(WIN_LEN + 1)) begin
                                win_we = (sn_p < 4'(WIN_LEN));
                                n_pos  = sn_p1;
                                if (sn_p1 > 4'd7) begin
                                    if (tag_hit) begin
                                        n_link = r_win[TAG_LEN] - CH_ZERO;
                                        fresh  = 1'b1;
                                    end
                                    n_pos = 4'd0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                KIND_RESTART: begin
                    n_cnt  = '0;
                    n_cr   = 1'b0;
                    n_done = 1'b0;
                    if (i_frames_wanted != 8'd0) n_frames = i_frames_wanted - 8'd1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_cr       <= 1'b0;
            r_done     <= 1'b0;
            r_frames   <= 8'd0;
            r_pos      <= 4'd0;
            r_link     <= 8'd0;
            r_wr2      <= 1'b0;
            r_rx_type  <= RXT_LINE;
            r_start    <= 8'd0;
            r_end      <= 8'd0;
            for (int k = 0; k < WIN_LEN; k++) r_win[k] <= 8'd0;
        end else begin
            r_cnt    <= n_cnt;
            r_cr     <= n_cr;
            r_done   <= n_done;
            r_frames <= n_frames;
            r_pos    <= n_pos;
            r_link   <= n_link;
            r_wr2    <= n_wr2;
            if (win_we) r_win[win_idx] <= i_rx_byte;
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_RX_TYPE:      r_rx_type <= i_cfg_data[1:0];
                    CFG_START_MARKER: r_start   <= i_cfg_data;
                    CFG_END_MARKER:   r_end     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr2_addr <= n_wr2_addr;
    end

    // the pending LF write owns the port ahead of any new write
    always_comb begin
        if (r_wr2) begin
            o_we    = 1'b1;
            o_waddr = r_wr2_addr;
            o_wdata = CH_LF;
        end else begin
            o_we    = w1_en;
            o_waddr = AW'(w1_pos);
            o_wdata = w1_data;
        end
    end

    assign o_busy                 = r_wr2;
    assign o_count                = 9'(n_cnt);
    assign o_status.frame_done    = n_done;
    assign o_status.cr_pending    = n_cr;
    assign o_status.link_id       = n_link;
    assign o_status.link_id_fresh = fresh;

endmodule

/* rtl/uart_rx_line_frame_collector.sv */
// top level: uart receive line, raw and marker frame collector
//
// Input channel (i_in_valid / o_in_stall) carries one item per beat: a
// received byte, a restart, a buffer read or a no-op. Every item gives
// exactly one result beat on the output channel (o_out_valid / i_out_stall)
// carrying the status after that item, plus buffer data for read items.
// Configuration writes use i_cfg_valid / o_cfg_ready, always ready; the user
// must make them while the block is idle, which the block does not enforce.
// A result is registered in the middle stage and then the output register.
// Throughput: one item per cycle while o_in_stall is low; an item that puts
// CR LF back into the buffer holds o_in_stall high while the single buffer
// port writes LF in the cycle after CR.
// The buffer is one single-port memory with registered reads.
// Reset clears status, link sniffing and configuration; buffer contents are
// undefined until written. When the receiver stalls, the output register
// holds and one more item is taken into the middle stage, then o_in_stall
// rises until the output drains.
module uart_rx_line_frame_collector #(
    parameter int BUF_DEPTH = ulfc_pkg::DEFAULT_BUF_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_frames_wanted,
    input  logic [7:0] i_read_index,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [8:0] o_received_count,
    output logic       o_frame_done,
    output logic       o_cr_pending,
    output logic [7:0] o_read_data,
    output logic [7:0] o_link_id,
    output logic       o_link_id_fresh
);
    import ulfc_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);

    logic          take, out_free;
    logic          w_busy, w_we, w_re;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata, w_rdata;
    logic [8:0]    w_count;
    t_status       w_status;

    logic          r_s1_valid;
    logic          r_s1_rd;
    logic [8:0]    r_s1_count;
    t_status       r_s1_status;

    logic          r_o_valid;
    logic [8:0]    r_o_count;
    logic [7:0]    r_o_rdata;
    t_status       r_o_status;

    assign out_free   = !r_o_valid || !i_out_stall;
    assign o_in_stall = w_busy || (r_s1_valid && !out_free);
    assign take       = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign w_re = take && (t_kind'(i_mode) == KIND_READ)
                  && (32'(i_read_index) < 32'(BUF_DEPTH));

    ulfc_ctrl #(.BUF_DEPTH(BUF_DEPTH), .AW(AW)) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_take          (take),
        .i_mode          (i_mode),
        .i_rx_byte       (i_rx_byte),
        .i_frames_wanted (i_frames_wanted),
        .o_busy          (w_busy),
        .o_we            (w_we),
        .o_waddr         (w_waddr),
        .o_wdata         (w_wdata),
        .o_count         (w_count),
        .o_status        (w_status)
    );

    ulfc_store #(.BUF_DEPTH(BUF_DEPTH), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (AW'(i_read_index)),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (take) begin
                r_s1_valid <= 1'b1;
            end else if (r_s1_valid && out_free) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_rd     <= w_re;
            r_s1_count  <= w_count;
            r_s1_status <= w_status;
        end
        if (out_free && r_s1_valid) begin
            r_o_count  <= r_s1_count;
            r_o_status <= r_s1_status;
            r_o_rdata  <= r_s1_rd ? w_rdata : 8'd0;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_received_count = r_o_count;
    assign o_frame_done     = r_o_status.frame_done;
    assign o_cr_pending     = r_o_status.cr_pending;
    assign o_read_data      = r_o_rdata;
    assign o_link_id        = r_o_status.link_id;
    assign o_link_id_fresh  = r_o_status.link_id_fresh;

    // buffer port never carries a read and a write together
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("buffer read and write in the same cycle");

    // the LF write is never still pending in the following cycle
    a_lf_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |=> !w_busy)
        else $error("LF write pending for more than one cycle");

    // a blocked middle stage keeps its item until the output drains
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> (r_s1_valid && $stable(r_s1_count)))
        else $error("middle stage lost its item while blocked");

    // no beat enters while the LF write is pending
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !take)
        else $error("beat accepted during LF write");

endmodule

/* sim/tb_top.sv */
// testbench for uart_rx_line_frame_collector: queued stimulus, line/raw/marker prediction, checks
`timescale 1ns / 100ps

module tb_top;
    import ulfc_pkg::*;

    localparam int BUF_DEPTH      = DEFAULT_BUF_DEPTH;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    // "+IPD," packed first byte highest
    localparam logic [39:0] IPD_TAG = {8'h2B, 8'h49, 8'h50, 8'h44, 8'h2C};

    typedef struct packed {
        logic [8:0] received_count;
        logic       frame_done;
        logic       cr_pending;
        logic [7:0] read_data;
        logic [7:0] link_id;
        logic       link_id_fresh;
    } rx_status_t;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] rx_byte;
        logic [7:0] frames_wanted;
        logic [7:0] read_index;
        rx_status_t status;
    } rx_item_t;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_cfg_valid     = 1'b0;
    logic [1:0] i_cfg_index     = 2'd0;
    logic [7:0] i_cfg_data      = 8'h00;
    logic       i_in_valid      = 1'b0;
    logic [1:0] i_mode          = 2'd0;
    logic [7:0] i_rx_byte       = 8'h00;
    logic [7:0] i_frames_wanted = 8'h00;
    logic [7:0] i_read_index    = 8'h00;
    logic       i_out_stall     = 1'b0;
    wire        o_cfg_ready;
    wire        o_in_stall;
    wire        o_out_valid;
    wire  [8:0] o_received_count;
    wire        o_frame_done;
    wire        o_cr_pending;
    wire  [7:0] o_read_data;
    wire  [7:0] o_link_id;
    wire        o_link_id_fresh;

    uart_rx_line_frame_collector #(
        .BUF_DEPTH(BUF_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_rx_byte       (i_rx_byte),
        .i_frames_wanted (i_frames_wanted),
        .i_read_index    (i_read_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_received_count(o_received_count),
        .o_frame_done    (o_frame_done),
        .o_cr_pending    (o_cr_pending),
        .o_read_data     (o_read_data),
        .o_link_id       (o_link_id),
        .o_link_id_fresh (o_link_id_fresh)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // collector shadow state
    logic [7:0] buf_mem [BUF_DEPTH];
    bit         buf_written [BUF_DEPTH];
    logic [7:0] written_list [$];
    int         col_count  = 0;
    bit         col_cr     = 1'b0;
    bit         col_done   = 1'b0;
    logic [7:0] lines_left = 8'h00;
    logic [7:0] ipd_win [WIN_LEN];
    int         ipd_pos    = 0;
    logic [7:0] link_last  = 8'h00;
    t_rx_type   cfg_rx_type = RXT_LINE;
    logic [7:0] cfg_start  = 8'h00;
    logic [7:0] cfg_end    = 8'h00;

    rx_item_t   pending_items [$];
    rx_status_t status_q [$];
    rx_item_t   drv_item;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_made    = 0;
    int links_made    = 0;
    int in_beats      = 0;
    int out_beats     = 0;
    int cfg_beats     = 0;
    int fail_count    = 0;
    int quiet_cycles  = 0;

    wire in_beat  = i_in_valid && !o_in_stall;
    wire out_beat = o_out_valid && !i_out_stall;
    wire cfg_beat = i_cfg_valid && o_cfg_ready;

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    // any byte but CR, so a line keeps going
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = rand_byte();
        if (b == CH_CR) begin
            b = 8'h20;
        end
        return b;
    endfunction

    // mostly a handful of lines, sometimes keep-count or a random count
    function automatic logic [7:0] frame_count();
        logic [31:0] r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return 8'h00;
        end else if (r < 30) begin
            return rand_byte();
        end
        r = $urandom_range(1, 4);
        return r[7:0];
    endfunction

    task automatic buf_put(int pos, logic [7:0] v);
        if (pos < BUF_DEPTH) begin
            buf_mem[pos] = v;
            if (!buf_written[pos]) begin
                buf_written[pos] = 1'b1;
                written_list.push_back(pos[7:0]);
            end
        end
    endtask

    task automatic line_accept(logic [7:0] b);
        if (col_done) begin
            return;
        end
        if (col_cr) begin
            if (b != CH_LF) begin
                col_count = 0;
                col_cr    = 1'b0;
            end else if (lines_left != 8'h00) begin
                // line ends: CR LF goes back into the buffer
                lines_left = lines_left - 8'd1;
                col_cr     = 1'b0;
                buf_put(col_count, CH_CR);
                buf_put(col_count + 1, CH_LF);
                col_count += 2;
                if (col_count > BUF_DEPTH) begin
                    col_count = BUF_DEPTH;
                end
            end else begin
                col_done = 1'b1;
            end
        end else if (b == CH_CR) begin
            col_cr = 1'b1;
        end else begin
            buf_put(col_count, b);
            col_count++;
            if (col_count > BUF_DEPTH - 1) begin
                col_count = 0;
            end
        end
    endtask

    task automatic raw_accept(logic [7:0] b);
        if (col_done) begin
            return;
        end
        buf_put(col_count, b);
        if (col_count < BUF_DEPTH - 1) begin
            col_count++;
        end else begin
            col_done = 1'b1;
        end
    endtask

    task automatic link_sniff(input logic [7:0] b, output bit fresh);
        bit hit;
        fresh = 1'b0;
        if (ipd_pos >= WIN_LEN + 1) begin
            return;
        end
        if (b == CH_PLUS) begin
            ipd_pos = 0;
        end
        if (ipd_pos < WIN_LEN) begin
            ipd_win[ipd_pos] = b;
        end
        ipd_pos++;
        if (ipd_pos > 7) begin
            hit = 1'b1;
            for (int k = 0; k < TAG_LEN; k++) begin
                if (ipd_win[k] != IPD_TAG[39 - 8 * k -: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                link_last = ipd_win[5] - CH_ZERO;
                fresh     = 1'b1;
            end
            ipd_pos = 0;
        end
    endtask

    task automatic marker_accept(input logic [7:0] b, output bit fresh);
        if (!col_done && !col_cr && col_count < BUF_DEPTH - 1) begin
            if (b == cfg_start) begin
                col_count = 0;
            end
            buf_put(col_count, b);
            col_count++;
            if (b == cfg_end) begin
                col_done = 1'b1;
            end
        end else begin
            // busy: byte dropped and status cleared
            col_count = 0;
            col_cr    = 1'b0;
            col_done  = 1'b0;
        end
        link_sniff(b, fresh);
    endtask

    // predicts the status for one item and queues it for the driver
    task automatic add_item(t_kind kind, logic [7:0] b, logic [7:0] want, logic [7:0] idx);
        rx_item_t   it;
        logic [7:0] rd;
        bit         fresh;
        rd    = 8'h00;
        fresh = 1'b0;
        case (kind)
            KIND_BYTE: begin
                case (cfg_rx_type)
                    RXT_LINE:   line_accept(b);
                    RXT_RAW:    raw_accept(b);
                    RXT_MARKER: marker_accept(b, fresh);
                    default:    ;
                endcase
            end
            KIND_RESTART: begin
                col_count = 0;
                col_cr    = 1'b0;
                col_done  = 1'b0;
                if (want != 8'h00) begin
                    lines_left = want - 8'd1;
                end
            end
            KIND_READ: begin
                if (idx < BUF_DEPTH) begin
                    rd = buf_mem[idx];
                end
            end
            default: ;
        endcase
        it.kind                  = kind;
        it.rx_byte               = b;
        it.frames_wanted         = want;
        it.read_index            = idx;
        it.status.received_count = col_count[8:0];
        it.status.frame_done     = col_done;
        it.status.cr_pending     = col_cr;
        it.status.read_data      = rd;
        it.status.link_id        = link_last;
        it.status.link_id_fresh  = fresh;
        pending_items.push_back(it);
        items_made++;
        if (fresh) begin
            links_made++;
        end
    endtask

    task automatic add_byte(logic [7:0] b);
        add_item(KIND_BYTE, b, rand_byte(), rand_byte());
    endtask

    task automatic add_nop();
        add_item(KIND_NOP, rand_byte(), rand_byte(), rand_byte());
    endtask

    task automatic add_restart(logic [7:0] want);
        add_item(KIND_RESTART, rand_byte(), want, rand_byte());
    endtask

    // reads only ever target entries that have been written
    task automatic add_read();
        if (written_list.size() == 0) begin
            add_nop();
        end else begin
            add_item(KIND_READ, rand_byte(), rand_byte(),
                     written_list[$urandom_range(0, written_list.size() - 1)]);
        end
    endtask

    // fills the buffer to 255; optionally closes with CR LF and one more byte
    task automatic long_line(logic [7:0] want, bit close);
        add_restart(want);
        repeat (BUF_DEPTH - 1) add_byte(text_byte());
        if (close) begin
            add_byte(CH_CR);
            add_byte(CH_LF);
            add_byte(text_byte());
        end
    endtask

    task automatic line_traffic(int n);
        int stop;
        int r;
        stop = items_made + n;
        while (items_made < stop) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                add_restart(frame_count());
            end else if (r < 20) begin
                add_read();
            end else if (r < 23) begin
                add_nop();
            end else if (r < 28) begin
                add_byte(rand_byte());
            end else if (r < 33) begin
                add_byte(CH_CR);
                add_byte(rand_byte());
            end else begin
                repeat ($urandom_range(0, 12)) add_byte(text_byte());
                add_byte(CH_CR);
                add_byte(CH_LF);
            end
        end
    endtask

    task automatic marker_traffic(int n);
        int          stop;
        int          r;
        int          bad;
        logic [7:0]  b;
        logic [31:0] d;
        stop = items_made + n;
        while (items_made < stop) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                add_restart(frame_count());
            end else if (r < 14) begin
                add_read();
            end else if (r < 17) begin
                add_nop();
            end else if (r < 25) begin
                add_byte(rand_byte());
            end else if (r < 55) begin
                add_byte(cfg_start);
                repeat ($urandom_range(0, 10)) add_byte(rand_byte());
                add_byte(cfg_end);
            end else begin
                // "+IPD," then link digit and two trailing bytes, sometimes damaged
                bad = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 4) : 0;
                for (int k = 0; k < TAG_LEN; k++) begin
                    b = IPD_TAG[39 - 8 * k -: 8];
                    if (bad != 0 && k == bad) begin
                        b = rand_byte();
                    end
                    add_byte(b);
                end
                d = $urandom_range(0, 9);
                add_byte(($urandom_range(0, 99) < 80) ? CH_ZERO + d[7:0] : rand_byte());
                repeat (2) begin
                    b = rand_byte();
                    add_byte((b == CH_PLUS) ? 8'h2E : b);
                end
            end
        end
    endtask

    task automatic raw_traffic();
        int r;
        add_restart(rand_byte());
        repeat (10) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                add_byte(rand_byte());
            end else if (r < 80) begin
                add_read();
            end else if (r < 90) begin
                add_nop();
            end else begin
                add_restart(rand_byte());
            end
        end
        // fill to full, then bytes are ignored
        add_restart(rand_byte());
        while (!col_done) begin
            if ($urandom_range(0, 99) < 4) begin
                add_read();
            end else begin
                add_byte(rand_byte());
            end
        end
        repeat (4) add_byte(rand_byte());
        repeat (6) add_read();
    endtask

    task automatic write_reg(t_cfg_index idx, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_RX_TYPE:      cfg_rx_type = t_rx_type'(data[1:0]);
            CFG_START_MARKER: cfg_start = data;
            CFG_END_MARKER:   cfg_end = data;
            default:          ;
        endcase
    endtask

    task automatic configure(t_rx_type rx, logic [7:0] smark, logic [7:0] emark);
        logic [31:0] r;
        r = $urandom;
        // upper bits of the mode write are don't-care
        write_reg(CFG_RX_TYPE, {r[5:0], rx});
        write_reg(CFG_START_MARKER, smark);
        write_reg(CFG_END_MARKER, emark);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || status_q.size() != 0);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // input driver: one beat in flight, held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                status_q.push_back(drv_item.status);
                in_beats++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    drv_item = pending_items.pop_front();
                    i_in_valid      <= 1'b1;
                    i_mode          <= drv_item.kind;
                    i_rx_byte       <= drv_item.rx_byte;
                    i_frames_wanted <= drv_item.frames_wanted;
                    i_read_index    <= drv_item.read_index;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        rx_status_t want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (out_beat) begin
                out_beats++;
                if (status_q.size() == 0) begin
                    $error("result beat with no item outstanding");
                    fail_count++;
                end else begin
                    want = status_q.pop_front();
                    check_field("received_count", want.received_count, o_received_count);
                    check_field("frame_done", want.frame_done, o_frame_done);
                    check_field("cr_pending", want.cr_pending, o_cr_pending);
                    check_field("read_data", want.read_data, o_read_data);
                    check_field("link_id", want.link_id, o_link_id);
                    check_field("link_id_fresh", want.link_id_fresh, o_link_id_fresh);
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (cfg_beat) begin
            cfg_beats++;
        end
        if (!i_rst_n || in_beat || out_beat || cfg_beat) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("uart_rx_line_frame_collector verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [7:0] smark;
        for (int k = 0; k < WIN_LEN; k++) begin
            ipd_win[k] = 8'h00;
        end
        for (int k = 0; k < BUF_DEPTH; k++) begin
            buf_mem[k]     = 8'h00;
            buf_written[k] = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 23;
        recv_idle_pct = 70;
        configure(RXT_LINE, 8'h00, 8'hFF);
        add_nop();
        add_restart(8'd2);
        add_byte(8'h41);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(CH_CR);
        add_byte(CH_LF);
        // bare CR: the next byte is dropped and the line restarts
        add_byte(8'h42);
        add_byte(CH_CR);
        add_byte(8'h43);
        add_byte(8'h44);
        add_byte(CH_CR);
        add_byte(CH_LF);
        // complete: ignored until restart
        add_byte(8'h45);
        add_item(KIND_READ, rand_byte(), rand_byte(), 8'd0);
        add_item(KIND_READ, rand_byte(), rand_byte(), 8'd4);
        add_item(KIND_READ, rand_byte(), rand_byte(), 8'd5);
        add_restart(8'd0);
        add_restart(8'hFF);
        add_item(KIND_READ, rand_byte(), rand_byte(), 8'd2);
        wait_idle();

        line_traffic(15);
        wait_idle();

        configure(RXT_MARKER, 8'h00, 8'hFF);
        marker_traffic(15);
        wait_idle();

        send_idle_pct = 70;
        recv_idle_pct = 23;
        configure(RXT_LINE, 8'h3C, 8'h3E);
        // CR LF at 255 saturates at the buffer size, next byte overflows
        long_line(8'd3, 1'b1);
        line_traffic(5);
        add_byte(CH_CR);
        wait_idle();

        configure(RXT_MARKER, 8'h3C, 8'h3E);
        marker_traffic(15);
        wait_idle();

        configure(RXT_RAW, 8'h55, 8'hAA);
        raw_traffic();
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_UNUSED, rand_byte());
        configure(RXT_INERT, rand_byte(), rand_byte());
        repeat (8) begin
            case ($urandom_range(0, 2))
                0:       add_byte(rand_byte());
                1:       add_read();
                default: add_nop();
            endcase
        end
        wait_idle();

        smark = rand_byte();
        configure(RXT_MARKER, smark, ($urandom_range(0, 99) < 25) ? smark : rand_byte());
        marker_traffic(10);
        wait_idle();

        configure(RXT_LINE, 8'hFF, 8'h00);
        line_traffic(10);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d items over line, raw, marker and inert modes with %0d register writes",
                 in_beats, cfg_beats);
        $display("%0d results checked, %0d of them with a new link id", out_beats, links_made);
        if (fail_count == 0 && status_q.size() == 0) begin
            $display("uart_rx_line_frame_collector verification clean");
        end else begin
            $display("uart_rx_line_frame_collector verification failed");
        end
        $finish;
    end

endmodule
